// ----- hdl/sha256_stream_hasher_macros.svh -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Immediate-cycle and next-cycle implication checks, compiled out with
// NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SHA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SHA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hdl/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Round constants, initial hash value, word queue entry and round functions.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam logic [3:0] LEN_HI_WPOS = 4'd14;

  localparam logic [31:0] SHA_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } q_entry_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big0(input logic [31:0] x);
    big0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big1(input logic [31:0] x);
    big1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small0(input logic [31:0] x);
    small0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small1(input logic [31:0] x);
    small1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ----- hdl/sha256_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-wide message absorber with padding, one-round-per-cycle compression
// and an eight-word digest output queue.
// ----------------------------------------------------------------------------
// channel  handshake        payload
// input    in_push/in_full  in_op, in_data_byte
// result   out_pop/out_empty out_digest_word, out_word_index, out_last_word
//
// Rounds run one per cycle, 64 per block, followed by a chaining-add step;
// rounds 0-15 also wait for words from the front end, which packs four
// message bytes into each word.
// A finish emits 3 to 18 padding words, then one or two blocks run before
// eight digest items appear, one per pop.
// Reset (synchronous) loads the initial hash value and clears the length.
// Input stalls while padding or while the four-word queue is full; the final
// block waits while a previous digest has not been fully popped.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_macros.svh"

module sha256_stream_hasher import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_op,
  input  logic [7:0]  in_data_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_valid;
  q_entry_t q_wentry;
  q_entry_t q_rentry;
  logic     fin_take;
  logic     dig_done;

  assign fin_take = in_push && !in_full && in_op;
  assign dig_done = out_pop && !out_empty && out_last_word;

  sha_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_op        (in_op),
    .in_data_byte (in_data_byte),
    .q_push       (q_push),
    .q_entry      (q_wentry),
    .q_full       (q_full)
  );

  sha_wq u_wq (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_push   (q_push),
    .q_wentry (q_wentry),
    .q_full   (q_full),
    .q_pop    (q_pop),
    .q_rentry (q_rentry),
    .q_valid  (q_valid)
  );

  sha_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_entry         (q_rentry),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  `SHA_ASSERT_SAME(a_no_push_full, clk, rst_n, q_push, !q_full, "word pushed into full queue")
  `SHA_ASSERT_SAME(a_no_pop_empty, clk, rst_n, q_pop, q_valid, "word popped from empty queue")
  `SHA_ASSERT_NEXT(a_finish_pads, clk, rst_n, fin_take, in_full, "no padding after finish")
  `SHA_ASSERT_NEXT(a_digest_done, clk, rst_n, dig_done, out_empty, "digest buffer not released")

endmodule

// ----- hdl/sha_front.sv -----
// ----------------------------------------------------------------------------
// SHA-256 front end
// Packs message bytes into big-endian words, counts the bit length and
// generates the padding words on finish.
// ----------------------------------------------------------------------------
module sha_front import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_op,
  input  logic [7:0]  in_data_byte,
  output logic        q_push,
  output q_entry_t    q_entry,
  input  logic        q_full
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_ZERO = 4'b0010,
    F_LENH = 4'b0100,
    F_LENL = 4'b1000
  } fstate_t;

  fstate_t     state_r, state_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [3:0]  wc_r, wc_nxt;
  logic        accept;
  logic [31:0] pad_word;

  assign in_full = (state_r != F_IDLE) || q_full;
  assign accept  = in_push && !in_full;

  always_comb begin
    case (pos_r[1:0])
      2'd0:    pad_word = {PAD_MARK, 24'd0};
      2'd1:    pad_word = {acc_r[7:0], PAD_MARK, 16'd0};
      2'd2:    pad_word = {acc_r[15:0], PAD_MARK, 8'd0};
      default: pad_word = {acc_r[23:0], PAD_MARK};
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    bits_nxt  = bits_r;
    acc_nxt   = acc_r;
    wc_nxt    = wc_r;
    q_push    = 1'b0;
    q_entry   = '0;
    unique case (state_r)
      F_IDLE: begin
        if (accept && !in_op) begin
          acc_nxt  = {acc_r[15:0], in_data_byte};
          pos_nxt  = pos_r + 6'd1;
          bits_nxt = bits_r + 64'd8;
          if (pos_r[1:0] == 2'd3) begin
            q_push       = 1'b1;
            q_entry.word = {acc_r, in_data_byte};
          end
        end else if (accept) begin
          q_push       = 1'b1;
          q_entry.word = pad_word;
          wc_nxt       = pos_r[5:2] + 4'd1;
          state_nxt    = (wc_nxt == LEN_HI_WPOS) ? F_LENH : F_ZERO;
        end
      end
      F_ZERO: begin
        if (!q_full) begin
          q_push    = 1'b1;
          wc_nxt    = wc_r + 4'd1;
          if (wc_nxt == LEN_HI_WPOS) begin
            state_nxt = F_LENH;
          end
        end
      end
      F_LENH: begin
        if (!q_full) begin
          q_push       = 1'b1;
          q_entry.word = bits_r[63:32];
          state_nxt    = F_LENL;
        end
      end
      F_LENL: begin
        if (!q_full) begin
          q_push       = 1'b1;
          q_entry.word = bits_r[31:0];
          q_entry.last = 1'b1;
          pos_nxt      = '0;
          bits_nxt     = '0;
          state_nxt    = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      pos_r   <= '0;
      bits_r  <= '0;
      wc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      bits_r  <= bits_nxt;
      wc_r    <= wc_nxt;
    end
    acc_r <= acc_nxt;
  end

endmodule

// ----- hdl/sha_wq.sv -----
// ----------------------------------------------------------------------------
// SHA-256 word queue
// Short FIFO of message words between the front end and the round engine.
// ----------------------------------------------------------------------------
module sha_wq import sha_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_push,
  input  q_entry_t q_wentry,
  output logic     q_full,
  input  logic     q_pop,
  output q_entry_t q_rentry,
  output logic     q_valid
);

  q_entry_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, wp_nxt;
  logic [Q_AW-1:0] rp_r, rp_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  assign q_full   = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_rentry = mem_r[rp_r];

  always_comb begin
    wp_nxt  = q_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = q_pop  ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (q_push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!q_push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (q_push) begin
      mem_r[wp_r] <= q_wentry;
    end
  end

endmodule

// ----- hdl/sha_core.sv -----
// ----------------------------------------------------------------------------
// SHA-256 round engine
// One compression round per cycle with a rolling 16-word schedule, chaining
// add, and an eight-word digest buffer that drains through the result port.
// ----------------------------------------------------------------------------
module sha_core import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  q_entry_t    q_entry,
  output logic        q_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  typedef enum logic [1:0] {
    B_RUN = 2'b01,
    B_ADD = 2'b10
  } bstate_t;

  bstate_t     state_r, state_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] chain_r [8];
  logic [31:0] chain_nxt [8];
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] dig_r [8];
  logic [31:0] dig_nxt [8];
  logic [31:0] sum [8];
  logic        last_blk_r, last_blk_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic        ovld_r, ovld_nxt;
  logic        need_word;
  logic        step;
  logic [31:0] w_new;
  logic [31:0] ch_v;
  logic [31:0] maj_v;
  logic [31:0] t1;
  logic [31:0] t2;

  assign need_word = (rnd_r[5:4] == 2'd0);
  assign q_pop     = (state_r == B_RUN) && need_word && q_valid;
  assign step      = (state_r == B_RUN) && (!need_word || q_valid);
  assign w_new     = need_word ? q_entry.word
                   : small1(w_r[14]) + w_r[9] + small0(w_r[1]) + w_r[0];
  assign ch_v      = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj_v     = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1        = v_r[7] + big1(v_r[4]) + ch_v + SHA_K[rnd_r] + w_new;
  assign t2        = big0(v_r[0]) + maj_v;

  assign out_empty       = !ovld_r;
  assign out_digest_word = dig_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sum[i] = chain_r[i] + v_r[i];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    rnd_nxt      = rnd_r;
    last_blk_nxt = last_blk_r;
    oidx_nxt     = oidx_r;
    ovld_nxt     = ovld_r;
    v_nxt        = v_r;
    chain_nxt    = chain_r;
    w_nxt        = w_r;
    dig_nxt      = dig_r;
    if (out_pop && ovld_r) begin
      oidx_nxt = oidx_r + 3'd1;
      if (oidx_r == 3'd7) begin
        ovld_nxt = 1'b0;
      end
    end
    unique case (state_r)
      B_RUN: begin
        if (step) begin
          for (int i = 0; i < 15; i++) begin
            w_nxt[i] = w_r[i+1];
          end
          w_nxt[15] = w_new;
          v_nxt[7]  = v_r[6];
          v_nxt[6]  = v_r[5];
          v_nxt[5]  = v_r[4];
          v_nxt[4]  = v_r[3] + t1;
          v_nxt[3]  = v_r[2];
          v_nxt[2]  = v_r[1];
          v_nxt[1]  = v_r[0];
          v_nxt[0]  = t1 + t2;
          rnd_nxt   = rnd_r + 6'd1;
          if (rnd_r == 6'd15) begin
            last_blk_nxt = q_entry.last;
          end
          if (rnd_r == 6'd63) begin
            state_nxt = B_ADD;
          end
        end
      end
      B_ADD: begin
        if (!last_blk_r) begin
          chain_nxt = sum;
          v_nxt     = sum;
          state_nxt = B_RUN;
        end else if (!ovld_r) begin
          dig_nxt   = sum;
          ovld_nxt  = 1'b1;
          oidx_nxt  = '0;
          chain_nxt = SHA_IV;
          v_nxt     = SHA_IV;
          state_nxt = B_RUN;
        end
      end
      default: state_nxt = B_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_RUN;
      rnd_r      <= '0;
      last_blk_r <= 1'b0;
      oidx_r     <= '0;
      ovld_r     <= 1'b0;
      v_r        <= SHA_IV;
      chain_r    <= SHA_IV;
    end else begin
      state_r    <= state_nxt;
      rnd_r      <= rnd_nxt;
      last_blk_r <= last_blk_nxt;
      oidx_r     <= oidx_nxt;
      ovld_r     <= ovld_nxt;
      v_r        <= v_nxt;
      chain_r    <= chain_nxt;
    end
    w_r   <= w_nxt;
    dig_r <= dig_nxt;
  end

endmodule

// ----- test/sha256_stream_hasher_tb.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds byte-wide messages and finish items through the push/full side and
// checks every digest word popped from the result side against an in-bench
// SHA-256 model. Directed cases cover empty and short messages; random
// messages cover the padding boundary and full blocks, with random stalls.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam int         BLOCK_BYTES  = 64;
  localparam int         LEN_OFFSET   = 56;
  localparam logic [7:0] PAD_BYTE     = 8'h80;
  localparam int         RANDOM_ITEMS = 170;
  localparam int         TAIL_ITEMS   = 40;
  localparam int         STALL_LIMIT  = 4000;
  localparam int         DRAIN_CYCLES = 300;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct {
    logic       op;
    logic [7:0] data;
  } byte_item_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_op = OP_ABSORB;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  byte_item_t   pending_items [$];
  digest_word_t digest_q [$];

  logic [31:0] hash_state [8];
  logic [7:0]  block_buf [64];
  int          fill_level;
  logic [63:0] msg_bits;

  int           errors = 0;
  int           in_gap = 0;
  int           out_gap = 0;
  int           idle_cycles = 0;
  bit           quiet_tail = 1'b0;
  logic         in_took = 1'b0;
  byte_item_t   next_item;
  byte_item_t   taken_item;
  digest_word_t want;

  always #1 clk = ~clk;

  sha256_stream_hasher dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_op           (in_op),
    .in_data_byte    (in_data_byte),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    logic [63:0] twice;
    twice = {x, x} >> n;
    return twice[31:0];
  endfunction

  function automatic void compress_block_buf();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7] +
             (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g)) +
           ROUND_K[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  function automatic void restart_hash();
    foreach (hash_state[i]) hash_state[i] = HASH_INIT[i];
    fill_level = 0;
    msg_bits = 64'd0;
  endfunction

  function automatic void predict_digest(input byte_item_t it);
    digest_word_t expd;
    if (it.op == OP_ABSORB) begin
      block_buf[fill_level] = it.data;
      fill_level++;
      msg_bits += 64'd8;
      if (fill_level == BLOCK_BYTES) begin
        compress_block_buf();
        fill_level = 0;
      end
    end else begin
      block_buf[fill_level] = PAD_BYTE;
      fill_level++;
      // no room left for the length: pad out and spend an extra block
      if (fill_level > LEN_OFFSET) begin
        while (fill_level < BLOCK_BYTES) begin
          block_buf[fill_level] = 8'h00;
          fill_level++;
        end
        compress_block_buf();
        fill_level = 0;
      end
      while (fill_level < LEN_OFFSET) begin
        block_buf[fill_level] = 8'h00;
        fill_level++;
      end
      for (int i = 0; i < 8; i++) block_buf[LEN_OFFSET+i] = msg_bits[63-8*i -: 8];
      compress_block_buf();
      for (int i = 0; i < 8; i++) begin
        expd.word  = hash_state[i];
        expd.index = 3'(i);
        expd.last  = (i == 7);
        digest_q.push_back(expd);
      end
      restart_hash();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("MISMATCH %s: got %h, expected %h", what, got, exp_val);
    errors++;
  endtask

  task automatic queue_item(input logic op, input logic [7:0] data);
    byte_item_t it;
    it.op = op;
    it.data = data;
    pending_items.push_back(it);
  endtask

  task automatic queue_message(input int len);
    for (int i = 0; i < len; i++) queue_item(OP_ABSORB, 8'($urandom_range(0, 255)));
    queue_item(OP_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // driver and result-side stalls
  always @(negedge clk) begin
    if (rst_n) begin
      quiet_tail = pending_items.size() < TAIL_ITEMS;
      if (!in_push || in_took) begin
        if (in_gap > 0) begin
          in_push <= 1'b0;
          in_gap--;
        end else if (pending_items.size() > 0) begin
          next_item = pending_items.pop_front();
          in_push <= 1'b1;
          in_op <= next_item.op;
          in_data_byte <= next_item.data;
          if (!quiet_tail && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 10);
        end else begin
          in_push <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_pop <= 1'b0;
        out_gap--;
      end else begin
        out_pop <= 1'b1;
        if (!quiet_tail && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 10);
      end
    end
  end

  // monitor, prediction and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      in_took <= in_push && !in_full;
      if (out_pop && !out_empty) begin
        if (digest_q.size() == 0) begin
          report_mismatch("digest word with none expected", out_digest_word, 32'h0);
        end else begin
          want = digest_q.pop_front();
          if (out_digest_word !== want.word)
            report_mismatch("digest_word", out_digest_word, want.word);
          if (out_word_index !== want.index)
            report_mismatch("word_index", 32'(out_word_index), 32'(want.index));
          if (out_last_word !== want.last)
            report_mismatch("last_word", 32'(out_last_word), 32'(want.last));
        end
      end
      if (in_push && !in_full) begin
        taken_item.op = in_op;
        taken_item.data = in_data_byte;
        predict_digest(taken_item);
      end
      if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int directed_count;
    int msg_count;
    int len;
    restart_hash();

    // empty message, twice back to back; the finish byte is ignored
    queue_item(OP_FINISH, 8'h00);
    queue_item(OP_FINISH, 8'hFF);
    // "abc"
    queue_item(OP_ABSORB, 8'h61);
    queue_item(OP_ABSORB, 8'h62);
    queue_item(OP_ABSORB, 8'h63);
    queue_item(OP_FINISH, 8'h5A);
    queue_item(OP_ABSORB, 8'h00);
    queue_item(OP_FINISH, 8'h00);
    queue_item(OP_ABSORB, 8'hFF);
    queue_item(OP_FINISH, 8'hFF);
    // pad marker value as message data
    queue_item(OP_ABSORB, 8'h80);
    queue_item(OP_ABSORB, 8'h7F);
    queue_item(OP_FINISH, 8'h80);
    directed_count = pending_items.size();

    // 55 bytes: last one-block pad, 56: first two-block pad, 64: exact full block
    msg_count = 0;
    while (pending_items.size() - directed_count < RANDOM_ITEMS) begin
      case (msg_count)
        0: begin
          len = 55;
        end
        1: begin
          len = 56;
        end
        2: begin
          len = 64;
        end
        default: begin
          len = $urandom_range(0, 20);
        end
      endcase
      queue_message(len);
      msg_count++;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_push) @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
